FILE: hw/rtl/dgr_pkg.sv
// Shared types, sizes and codes for the graph reachability block.
// No dependencies; every other file imports this package.
package dgr_pkg;

  localparam int unsigned NODE_COUNT = 64;
  localparam int unsigned NODE_W     = $clog2(NODE_COUNT);
  localparam int unsigned OP_W       = 2;

  typedef logic [NODE_COUNT-1:0] node_row_t;
  typedef logic [NODE_W-1:0]     node_idx_t;

  typedef enum logic [OP_W-1:0] {
    OP_CONNECT    = 2'd0,
    OP_DISCONNECT = 2'd1,
    OP_FORBID     = 2'd2,
    OP_QUERY      = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_A,
    ST_WR_A,
    ST_RD_B,
    ST_WR_B,
    ST_FORB_RD,
    ST_FORB_WR,
    ST_Q_FORB,
    ST_Q_LOAD,
    ST_Q_ISSUE,
    ST_Q_MERGE,
    ST_DONE
  } walk_state_e;

  typedef struct packed {
    node_idx_t adj_raddr;
    logic      adj_we;
    node_idx_t adj_waddr;
    node_row_t adj_wdata;
    node_idx_t forb_raddr;
    logic      forb_we;
    node_idx_t forb_waddr;
    node_row_t forb_wdata;
  } store_req_t;

  typedef struct packed {
    node_row_t adj_rdata;
    node_row_t forb_rdata;
  } store_rsp_t;

  function automatic node_idx_t lowest_set(input node_row_t row);
    node_idx_t idx;
    idx = '0;
    for (int i = NODE_COUNT - 1; i >= 0; i--) begin
      if (row[i]) begin
        idx = node_idx_t'(i);
      end
    end
    return idx;
  endfunction

endpackage

FILE: hw/rtl/dgr_if.sv
// Valid/ready channel interfaces for operation items and query results.
// Imports dgr_pkg, though the field widths are written as fixed literals.
interface dgr_item_if
  import dgr_pkg::*;
();
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [5:0] first_node;
  logic [5:0] second_node;

  modport source (output valid, output operation, output first_node, output second_node,
                  input ready);
  modport sink   (input valid, input operation, input first_node, input second_node,
                  output ready);
endinterface

interface dgr_result_if;
  logic valid;
  logic ready;
  logic reachable;

  modport source (output valid, output reachable, input ready);
  modport sink   (input valid, input reachable, output ready);
endinterface

FILE: hw/rtl/dgr_store.sv
// Adjacency and forbidden-node row memories with one-cycle registered reads.
// Per-row valid flops make unwritten rows read as zero after reset. Uses dgr_pkg.
module dgr_store
  import dgr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  store_req_t req_i,
  output store_rsp_t rsp_o
);

  node_row_t adj_mem  [NODE_COUNT];
  node_row_t forb_mem [NODE_COUNT];
  logic [NODE_COUNT-1:0] adj_vld_q;
  logic [NODE_COUNT-1:0] forb_vld_q;
  node_row_t adj_rd_q;
  node_row_t forb_rd_q;
  logic      adj_rv_q;
  logic      forb_rv_q;

  always_ff @(posedge clk_i) begin
    if (req_i.adj_we) begin
      adj_mem[req_i.adj_waddr] <= req_i.adj_wdata;
    end
    if (req_i.forb_we) begin
      forb_mem[req_i.forb_waddr] <= req_i.forb_wdata;
    end
    adj_rd_q  <= adj_mem[req_i.adj_raddr];
    forb_rd_q <= forb_mem[req_i.forb_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adj_vld_q  <= '0;
      forb_vld_q <= '0;
      adj_rv_q   <= 1'b0;
      forb_rv_q  <= 1'b0;
    end else begin
      if (req_i.adj_we) begin
        adj_vld_q[req_i.adj_waddr] <= 1'b1;
      end
      if (req_i.forb_we) begin
        forb_vld_q[req_i.forb_waddr] <= 1'b1;
      end
      adj_rv_q  <= adj_vld_q[req_i.adj_raddr];
      forb_rv_q <= forb_vld_q[req_i.forb_raddr];
    end
  end

  assign rsp_o.adj_rdata  = adj_rv_q  ? adj_rd_q  : '0;
  assign rsp_o.forb_rdata = forb_rv_q ? forb_rd_q : '0;

endmodule

FILE: hw/rtl/dgr_walk.sv
// Operation sequencer: read-modify-write of matrix rows and the query walk
// over visited and pending sets. Drives dgr_store through store_req_t. Uses dgr_pkg.
module dgr_walk
  import dgr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  op_e        op_i,
  input  node_idx_t  a_i,
  input  node_idx_t  b_i,
  output store_req_t req_o,
  input  store_rsp_t rsp_i,
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output logic       res_bit_o
);

  walk_state_e state_q, state_d;
  op_e         op_q;
  node_idx_t   a_q, b_q;
  node_row_t   visited_q, visited_d;
  node_row_t   pending_q, pending_d;
  node_row_t   forb_q, forb_d;
  node_idx_t   next_node;
  node_row_t   fresh;
  logic        in_xfer;

  assign in_xfer   = in_valid_i && in_ready_o;
  assign next_node = lowest_set(pending_q);
  assign fresh     = rsp_i.adj_rdata & ~visited_q & ~forb_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (op_i)
            OP_CONNECT, OP_DISCONNECT: state_d = ST_RD_A;
            OP_FORBID:                 state_d = ST_FORB_RD;
            default:                   state_d = ST_Q_FORB;
          endcase
        end
      end
      ST_RD_A:    state_d = ST_WR_A;
      ST_WR_A:    state_d = ST_RD_B;
      ST_RD_B:    state_d = ST_WR_B;
      ST_WR_B:    state_d = ST_IDLE;
      ST_FORB_RD: state_d = ST_FORB_WR;
      ST_FORB_WR: state_d = ST_IDLE;
      ST_Q_FORB:  state_d = ST_Q_LOAD;
      ST_Q_LOAD:  state_d = ST_Q_ISSUE;
      ST_Q_ISSUE: state_d = (pending_q == '0) ? ST_DONE : ST_Q_MERGE;
      ST_Q_MERGE: state_d = ST_Q_ISSUE;
      ST_DONE:    state_d = res_ready_i ? ST_IDLE : ST_DONE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == ST_IDLE);
    res_valid_o = (state_q == ST_DONE);
    res_bit_o   = visited_q[b_q];
    visited_d   = visited_q;
    pending_d   = pending_q;
    forb_d      = forb_q;
    req_o       = '0;
    case (state_q)
      ST_RD_A: req_o.adj_raddr = a_q;
      ST_WR_A: begin
        req_o.adj_we    = 1'b1;
        req_o.adj_waddr = a_q;
        req_o.adj_wdata = (op_q == OP_CONNECT)
                        ? (rsp_i.adj_rdata | (node_row_t'(1) << b_q))
                        : (rsp_i.adj_rdata & ~(node_row_t'(1) << b_q));
      end
      ST_RD_B: req_o.adj_raddr = b_q;
      ST_WR_B: begin
        req_o.adj_we    = 1'b1;
        req_o.adj_waddr = b_q;
        req_o.adj_wdata = (op_q == OP_CONNECT)
                        ? (rsp_i.adj_rdata | (node_row_t'(1) << a_q))
                        : (rsp_i.adj_rdata & ~(node_row_t'(1) << a_q));
      end
      ST_FORB_RD: req_o.forb_raddr = a_q;
      ST_FORB_WR: begin
        req_o.forb_we    = 1'b1;
        req_o.forb_waddr = a_q;
        req_o.forb_wdata = rsp_i.forb_rdata | (node_row_t'(1) << b_q);
      end
      ST_Q_FORB: begin
        req_o.forb_raddr = a_q;
        visited_d        = node_row_t'(1) << a_q;
        pending_d        = node_row_t'(1) << a_q;
      end
      ST_Q_LOAD: forb_d = rsp_i.forb_rdata;
      ST_Q_ISSUE: begin
        req_o.adj_raddr = next_node;
        pending_d       = pending_q & ~(node_row_t'(1) << next_node);
      end
      ST_Q_MERGE: begin
        visited_d = visited_q | fresh;
        pending_d = pending_q | fresh;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      visited_q <= '0;
      pending_q <= '0;
    end else begin
      state_q   <= state_d;
      visited_q <= visited_d;
      pending_q <= pending_d;
    end
  end

  always_ff @(posedge clk_i) begin
    forb_q <= forb_d;
    if (in_xfer) begin
      op_q <= op_i;
      a_q  <= a_i;
      b_q  <= b_i;
    end
  end

  a_pending_visited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_Q_ISSUE || state_q == ST_Q_MERGE) |-> ((pending_q & ~visited_q) == '0))
    else $error("pending node not marked visited");

  a_source_visited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_Q_ISSUE || state_q == ST_Q_MERGE || state_q == ST_DONE) |-> visited_q[a_q])
    else $error("query source dropped from visited set");

  a_visited_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_Q_MERGE) |=> ((visited_q & $past(visited_q)) == $past(visited_q)))
    else $error("visited set lost a node");

  a_no_write_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_Q_ISSUE || state_q == ST_Q_MERGE) |-> (!req_o.adj_we && !req_o.forb_we))
    else $error("matrix write during query walk");

endmodule

FILE: hw/rtl/dynamic_graph_reachability_top.sv
// Connect/disconnect read and write row A, then row B; forbid reads and writes the
// forbidden row of A; a query loads it, then reads a row per node expanded (at most 64).
// Throughput: one item at a time; the next item is taken on return to idle.
// The result register lets the next item start while a result waits.
// Reset clears both matrices at once through per-row valid flops; no clearing pass.
module dynamic_graph_reachability_top
  import dgr_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  dgr_item_if.sink      item_i,
  dgr_result_if.source  result_o
);

  store_req_t store_req;
  store_rsp_t store_rsp;
  logic       res_valid;
  logic       res_ready;
  logic       res_bit;
  logic       out_valid_q, out_valid_d;
  logic       out_bit_q;

  dgr_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (store_req),
    .rsp_o  (store_rsp)
  );

  dgr_walk u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (item_i.ready),
    .op_i        (op_e'(item_i.operation)),
    .a_i         (node_idx_t'(item_i.first_node)),
    .b_i         (node_idx_t'(item_i.second_node)),
    .req_o       (store_req),
    .rsp_i       (store_rsp),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_bit_o   (res_bit)
  );

  assign res_ready = !out_valid_q || result_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_bit_q <= res_bit;
    end
  end

  assign result_o.valid     = out_valid_q;
  assign result_o.reachable = out_bit_q;

endmodule

FILE: sim/tb_dynamic_graph_reachability_top.sv
// Testbench for dynamic_graph_reachability_top: random connect, disconnect, forbid and
// reach-query traffic, each query answer checked against a walk over a local graph copy.
// Depends on dgr_pkg, dgr_if.sv and the top-level RTL.
module tb_dynamic_graph_reachability_top;
  import dgr_pkg::*;

  localparam int unsigned OPS_PER_PHASE = 540;
  localparam int unsigned LINK_CAP      = 70;

  typedef struct packed {
    op_e       op;
    node_idx_t a;
    node_idx_t b;
  } graph_op_t;

  typedef struct packed {
    node_idx_t a;
    node_idx_t b;
  } link_t;

  logic clk_i;
  logic rst_n;

  dgr_item_if   item_bus ();
  dgr_result_if result_bus ();

  dynamic_graph_reachability_top u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_n),
    .item_i  (item_bus),
    .result_o(result_bus)
  );

  node_row_t   adj_model [NODE_COUNT];
  node_row_t   forb_model[NODE_COUNT];
  graph_op_t   op_q[$];
  bit          reach_answers_q[$];
  link_t       live_links[$];
  graph_op_t   next_op;
  int unsigned op_total;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned err_count;

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic bit walk_reach(node_idx_t src, node_idx_t dst);
    node_row_t seen;
    node_row_t frontier;
    node_row_t fresh;
    int        n;
    seen = '0;
    seen[src] = 1'b1;
    frontier = seen;
    while (frontier != '0) begin
      n = 0;
      while (!frontier[n]) n++;
      frontier[n] = 1'b0;
      fresh = adj_model[n] & ~seen & ~forb_model[src];
      seen |= fresh;
      frontier |= fresh;
    end
    return seen[dst];
  endfunction

  task automatic update_graph(op_e op, node_idx_t a, node_idx_t b);
    bit answer;
    case (op)
      OP_CONNECT: begin
        adj_model[a][b] = 1'b1;
        adj_model[b][a] = 1'b1;
      end
      OP_DISCONNECT: begin
        adj_model[a][b] = 1'b0;
        adj_model[b][a] = 1'b0;
      end
      OP_FORBID: begin
        forb_model[a][b] = 1'b1;
      end
      default: begin
        answer = walk_reach(a, b);
        reach_answers_q = {reach_answers_q, answer};
      end
    endcase
  endtask

  task automatic push_op(op_e op, node_idx_t a, node_idx_t b);
    graph_op_t g;
    link_t     l;
    g.op = op;
    g.a  = a;
    g.b  = b;
    op_q = {op_q, g};
    op_total++;
    if (op == OP_CONNECT) begin
      l.a = a;
      l.b = b;
      live_links = {live_links, l};
    end
  endtask

  function automatic node_idx_t any_node();
    return node_idx_t'($urandom_range(NODE_COUNT - 1));
  endfunction

  task automatic wait_quiet();
    while (op_q.size() != 0 || item_bus.valid || reach_answers_q.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic drop_link();
    int    k;
    link_t l;
    k = $urandom_range(live_links.size() - 1);
    l = live_links[k];
    live_links.delete(k);
    push_op(OP_DISCONNECT, l.a, l.b);
  endtask

  task automatic push_path();
    node_idx_t path[8];
    int        len;
    len = $urandom_range(2, 7);
    path[0] = any_node();
    for (int i = 1; i <= len; i++) begin
      path[i] = any_node();
      push_op(OP_CONNECT, path[i-1], path[i]);
    end
    case ($urandom_range(9))
      0, 1:    push_op(OP_FORBID, path[0], path[$urandom_range(1, len)]);
      2:       push_op(OP_DISCONNECT, path[len/2], path[len/2 + 1]);
      default: ;
    endcase
    push_op(OP_QUERY, path[0], path[len]);
  endtask

  task automatic push_random_op();
    int unsigned r;
    node_idx_t   a;
    r = $urandom_range(99);
    a = any_node();
    if (r < 8) begin
      push_op(OP_FORBID, a, any_node());
    end else if (r < 38) begin
      if (live_links.size() > LINK_CAP)
        drop_link();
      else if ($urandom_range(1))
        push_op(OP_CONNECT, a, a + node_idx_t'($urandom_range(1, 3)));
      else
        push_op(OP_CONNECT, a, any_node());
    end else if (r < 62) begin
      if (live_links.size() != 0 && $urandom_range(9) < 8)
        drop_link();
      else
        push_op(OP_DISCONNECT, a, any_node());
    end else if (r < 92) begin
      case ($urandom_range(9))
        0:       push_op(OP_QUERY, a, a);
        1, 2:    push_op(OP_QUERY, a, a + node_idx_t'($urandom_range(1, 4)));
        default: push_op(OP_QUERY, a, any_node());
      endcase
    end else begin
      push_path();
    end
  endtask

  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      item_bus.valid       <= 1'b0;
      item_bus.operation   <= OP_CONNECT;
      item_bus.first_node  <= '0;
      item_bus.second_node <= '0;
    end else begin
      if (item_bus.valid && item_bus.ready)
        update_graph(op_e'(item_bus.operation), item_bus.first_node, item_bus.second_node);
      if (!item_bus.valid || item_bus.ready) begin
        if (op_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_op = op_q.pop_front();
          item_bus.valid       <= 1'b1;
          item_bus.operation   <= next_op.op;
          item_bus.first_node  <= next_op.a;
          item_bus.second_node <= next_op.b;
        end else begin
          item_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      result_bus.ready <= 1'b0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        if (reach_answers_q.size() == 0) begin
          $error("reachable: no query pending, expected none, actual %0b",
                 result_bus.reachable);
          err_count++;
        end else if (reach_answers_q[0] !== result_bus.reachable) begin
          $error("reachable: expected %0b, actual %0b", reach_answers_q[0],
                 result_bus.reachable);
          err_count++;
          void'(reach_answers_q.pop_front());
        end else begin
          void'(reach_answers_q.pop_front());
        end
      end
      result_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    #40_000_000;
    $display("tb_dynamic_graph_reachability_top: done, errors");
    $finish;
  end

  initial begin
    err_count     = 0;
    op_total      = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < NODE_COUNT; i++) begin
      adj_model[i]  = '0;
      forb_model[i] = '0;
    end
    rst_n = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_n <= 1'b1;

    push_op(OP_QUERY, 6'd0, 6'd0);
    push_op(OP_QUERY, 6'd0, 6'd63);
    push_op(OP_CONNECT, 6'd0, 6'd63);
    push_op(OP_QUERY, 6'd63, 6'd0);
    push_op(OP_CONNECT, 6'd63, 6'd0);
    push_op(OP_DISCONNECT, 6'd0, 6'd63);
    push_op(OP_QUERY, 6'd0, 6'd63);
    push_op(OP_DISCONNECT, 6'd0, 6'd63);
    push_op(OP_CONNECT, 6'd5, 6'd5);
    push_op(OP_QUERY, 6'd5, 6'd5);
    push_op(OP_QUERY, 6'd5, 6'd6);
    push_op(OP_CONNECT, 6'd1, 6'd2);
    push_op(OP_CONNECT, 6'd2, 6'd3);
    push_op(OP_QUERY, 6'd1, 6'd3);
    push_op(OP_FORBID, 6'd1, 6'd2);
    push_op(OP_QUERY, 6'd1, 6'd3);
    push_op(OP_QUERY, 6'd3, 6'd1);
    push_op(OP_QUERY, 6'd1, 6'd2);
    push_op(OP_FORBID, 6'd3, 6'd3);
    push_op(OP_QUERY, 6'd3, 6'd3);
    push_op(OP_QUERY, 6'd3, 6'd1);
    push_op(OP_CONNECT, 6'd42, 6'd21);
    push_op(OP_FORBID, 6'd63, 6'd0);
    push_op(OP_QUERY, 6'd21, 6'd42);
    push_op(OP_QUERY, 6'd63, 6'd0);
    wait_quiet();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 38;
          recv_idle_pct = 45;
        end
        1: begin
          send_idle_pct = 45;
          recv_idle_pct = 38;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      op_total = 0;
      while (op_total < OPS_PER_PHASE) push_random_op();
      wait_quiet();
    end

    repeat (160) @(posedge clk_i);
    if (err_count == 0 && reach_answers_q.size() == 0) begin
      $display("tb_dynamic_graph_reachability_top: done, clean");
    end else begin
      $display("tb_dynamic_graph_reachability_top: done, errors");
    end
    $finish;
  end

endmodule
